@@ sv/qenc_pkg.sv @@
// qenc_pkg: shared types, constants, saturation helper and the microprogram
// for the encoder angle and speed estimator. No dependencies.
package qenc_pkg;

   localparam int POS_W      = 16;
   localparam int COUNT_BITS = 16;
   localparam logic [POS_W-1:0] COUNT_MASK = POS_W'((64'd1 << COUNT_BITS) - 64'd1);

   localparam int PP_W   = 6;
   localparam int CPR_W  = 16;
   localparam int COEF_W = 18;
   localparam int ANG_W  = 19;
   localparam int WORD_W = 32;
   localparam int CSR_IDX_W = 3;

   localparam int MUL_W  = 33;             // signed operand width
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = 52;

   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 136;

   localparam logic [WORD_W-1:0] TWO_PI_Q29         = 32'd3373259426;
   localparam logic [WORD_W-1:0] TWO_PI_OVER_60_Q32 = 32'd449767924;

   localparam logic [PP_W-1:0]   PP_RESET   = 6'd3;
   localparam logic [CPR_W-1:0]  CPR_RESET  = 16'd14400;
   localparam logic [WORD_W-1:0] INV_RESET  = 32'd298262;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POLE_CNT     = 3'd0,
      CSR_COUNTS_REV   = 3'd1,
      CSR_INV_COUNTS   = 3'd2,
      CSR_RPM_PER_CNT  = 3'd3,
      CSR_FILTER_A     = 3'd4,
      CSR_FILTER_B     = 3'd5
   } csr_idx_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   // multiplier operand pair for a step
   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_FRAC,     // position * inv_counts_per_rev
      MUL_RAW,      // corrected diff * rpm_per_count
      MUL_EFRAC,    // mech fraction * pole count
      MUL_MANG,     // mech fraction * 2pi
      MUL_EANG,     // elec fraction * 2pi
      MUL_FA,       // filter_a * lowpass
      MUL_FB,       // filter_b * (raw + previous raw)
      MUL_MECH,     // lowpass * 2pi/60
      MUL_ELEC      // mech speed * pole count
   } mul_sel_type;

   // where the product of the previous step goes
   typedef enum logic [3:0] {
      WB_NONE,
      WB_FRAC,
      WB_RAW,
      WB_EFRAC,
      WB_MANG,
      WB_EANG,
      WB_ACC,
      WB_LOW,
      WB_MECH,
      WB_ELEC
   } wb_sel_type;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_NO_STROBE,   // skip the speed update
      JMP_EMIT         // end of program, hand result to the output register
   } jmp_type;

   typedef struct packed {
      mul_sel_type mul;
      wb_sel_type  wb;
      jmp_type     jmp;
   } ucode_type;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_FIRST = 4'd0;
   localparam logic [STEP_W-1:0] STEP_DONE  = 4'd12;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type uc;
      unique case (step)
         4'd0:    uc = '{MUL_FRAC,  WB_NONE,  JMP_NEXT};
         4'd1:    uc = '{MUL_RAW,   WB_FRAC,  JMP_NEXT};
         4'd2:    uc = '{MUL_EFRAC, WB_RAW,   JMP_NEXT};
         4'd3:    uc = '{MUL_MANG,  WB_EFRAC, JMP_NEXT};
         4'd4:    uc = '{MUL_EANG,  WB_MANG,  JMP_NEXT};
         4'd5:    uc = '{MUL_FA,    WB_EANG,  JMP_NO_STROBE};
         4'd6:    uc = '{MUL_FB,    WB_ACC,   JMP_NEXT};
         4'd7:    uc = '{MUL_NONE,  WB_LOW,   JMP_NEXT};
         4'd8:    uc = '{MUL_MECH,  WB_NONE,  JMP_NEXT};
         4'd9:    uc = '{MUL_NONE,  WB_MECH,  JMP_NEXT};
         4'd10:   uc = '{MUL_ELEC,  WB_NONE,  JMP_NEXT};
         4'd11:   uc = '{MUL_NONE,  WB_ELEC,  JMP_NEXT};
         default: uc = '{MUL_NONE,  WB_NONE,  JMP_EMIT};
      endcase
      return uc;
   endfunction

   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] max_v;
      logic signed [PROD_W-1:0] min_v;
      max_v = 66'sd2147483647;
      min_v = -66'sd2147483648;
      if (v > max_v) begin
         return 32'sh7FFF_FFFF;
      end else if (v < min_v) begin
         return 32'sh8000_0000;
      end
      return v[WORD_W-1:0];
   endfunction

endpackage

@@ sv/encoder_angle_speed_estimator.sv @@
// encoder_angle_speed_estimator: top level, microcoded sequencer around one
// shared 33x33 signed multiplier. Depends on qenc_pkg.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+---------------------------------------------
//   req     | in  | req_tvalid/tready  | tdata: position_count; tuser: direction, sample
//   rsp     | out | rsp_tvalid/tready  | tdata: angles, rpm_filtered, mech/elec speed
//   csr     | in  | csr_we             | csr_addr register index, csr_wdata value
//
// An item runs its microprogram steps in order after the accept cycle, the speed-update
// steps being skipped without speed_sample, all of them sharing the one multiplier;
// no new item is accepted until the sequencer is back in idle.
// Synchronous active-high reset restores the register defaults and zeros the speed state.
// A finished result waits in the output register; the next item is accepted meanwhile,
// and the sequencer holds on its last step only if that register is still occupied.
module encoder_angle_speed_estimator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [qenc_pkg::REQ_DATA_W-1:0]  req_tdata,  // [15:0] position_count
   input  logic [qenc_pkg::REQ_USER_W-1:0]  req_tuser,  // [0] direction_forward, [1] speed_sample
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [18:0] mech_angle, [37:19] elec_angle, [69:38] rpm_filtered,
   // [101:70] mech_speed, [133:102] elec_speed, [135:134] zero
   output logic [qenc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_we,
   input  logic [qenc_pkg::CSR_IDX_W-1:0]   csr_addr,
   input  logic [31:0]                      csr_wdata
);
   import qenc_pkg::*;

   // configuration
   logic [PP_W-1:0]          poles_ff;
   logic [CPR_W-1:0]         cpr_ff;
   logic [WORD_W-1:0]        inv_cpr_ff;
   logic [WORD_W-1:0]        rpm_per_cnt_ff;
   logic signed [COEF_W-1:0] filt_a_ff;
   logic signed [COEF_W-1:0] filt_b_ff;

   // speed state
   logic [POS_W-1:0]         sampled_ff;
   logic signed [WORD_W-1:0] low_ff;
   logic signed [WORD_W-1:0] prev_ff;
   logic signed [WORD_W-1:0] mech_ff;
   logic signed [WORD_W-1:0] elec_ff;

   // sequencer
   seq_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   ucode_type         uc;
   logic              accept;
   logic              emit;
   logic              out_free;

   // item and scratch registers
   logic [POS_W-1:0]         pos_ff;
   logic                     fwd_ff;
   logic                     strobe_ff;
   logic [WORD_W-1:0]        frac_ff;
   logic [WORD_W-1:0]        efrac_ff;
   logic [ANG_W-1:0]         mang_ff;
   logic [ANG_W-1:0]         eang_ff;
   logic signed [WORD_W-1:0] raw_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [PROD_W-1:0] prod_ff;

   logic signed [MUL_W-1:0]  op_a;
   logic signed [MUL_W-1:0]  op_b;
   logic signed [17:0]       diff_raw;
   logic signed [17:0]       diff;
   logic signed [MUL_W-1:0]  raw_sum;
   logic signed [ACC_W:0]    acc_sum;
   logic signed [ACC_W-16:0] acc_shr;

   logic                     rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]    rsp_tdata_ff;

   assign uc       = ucode_rom(step_ff);
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // ---------------- configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         poles_ff       <= PP_RESET;
         cpr_ff         <= CPR_RESET;
         inv_cpr_ff     <= INV_RESET;
         rpm_per_cnt_ff <= '0;
         filt_a_ff      <= '0;
         filt_b_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_POLE_CNT:    poles_ff       <= csr_wdata[PP_W-1:0];
            CSR_COUNTS_REV:  cpr_ff         <= csr_wdata[CPR_W-1:0];
            CSR_INV_COUNTS:  inv_cpr_ff     <= csr_wdata;
            CSR_RPM_PER_CNT: rpm_per_cnt_ff <= csr_wdata;
            CSR_FILTER_A:    filt_a_ff      <= csr_wdata[COEF_W-1:0];
            CSR_FILTER_B:    filt_b_ff      <= csr_wdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- sequencer control
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_tvalid) begin
               state_in = SEQ_RUN;
               step_in  = STEP_FIRST;
            end
         end
         SEQ_RUN: begin
            unique case (uc.jmp)
               JMP_NEXT:      step_in = step_ff + 1'b1;
               JMP_NO_STROBE: step_in = strobe_ff ? step_ff + 1'b1 : STEP_DONE;
               JMP_EMIT: begin
                  if (out_free) begin
                     state_in = SEQ_IDLE;
                  end
               end
               default: step_in = STEP_DONE;
            endcase
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      emit       = 1'b0;
      unique case (state_ff)
         SEQ_IDLE: req_tready = 1'b1;
         SEQ_RUN:  emit = (uc.jmp == JMP_EMIT) && out_free;
         default: ;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff  <= STEP_FIRST;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff    <= req_tdata[POS_W-1:0] & COUNT_MASK;
         fwd_ff    <= req_tuser[0];
         strobe_ff <= req_tuser[1];
      end
   end

   // ---------------- datapath
   // wrap correction: the count difference follows the reported direction
   assign diff_raw = $signed({2'b00, pos_ff}) - $signed({2'b00, sampled_ff});
   always_comb begin
      priority if (fwd_ff && diff_raw < 0) begin
         diff = diff_raw + $signed({2'b00, cpr_ff});
      end else if (!fwd_ff && diff_raw > 0) begin
         diff = diff_raw - $signed({2'b00, cpr_ff});
      end else begin
         diff = diff_raw;
      end
   end

   assign raw_sum = {raw_ff[WORD_W-1], raw_ff} + {prev_ff[WORD_W-1], prev_ff};

   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (uc.mul)
         MUL_NONE: ;
         MUL_FRAC: begin
            op_a = {{(MUL_W-POS_W){1'b0}}, pos_ff};
            op_b = {1'b0, inv_cpr_ff};
         end
         MUL_RAW: begin
            op_a = {{(MUL_W-18){diff[17]}}, diff};
            op_b = {1'b0, rpm_per_cnt_ff};
         end
         MUL_EFRAC: begin
            op_a = {1'b0, frac_ff};
            op_b = {{(MUL_W-PP_W){1'b0}}, poles_ff};
         end
         MUL_MANG: begin
            op_a = {1'b0, frac_ff};
            op_b = {1'b0, TWO_PI_Q29};
         end
         MUL_EANG: begin
            op_a = {1'b0, efrac_ff};
            op_b = {1'b0, TWO_PI_Q29};
         end
         MUL_FA: begin
            op_a = {{(MUL_W-COEF_W){filt_a_ff[COEF_W-1]}}, filt_a_ff};
            op_b = {low_ff[WORD_W-1], low_ff};
         end
         MUL_FB: begin
            op_a = {{(MUL_W-COEF_W){filt_b_ff[COEF_W-1]}}, filt_b_ff};
            op_b = raw_sum;
         end
         MUL_MECH: begin
            op_a = {low_ff[WORD_W-1], low_ff};
            op_b = {1'b0, TWO_PI_OVER_60_Q32};
         end
         MUL_ELEC: begin
            op_a = {mech_ff[WORD_W-1], mech_ff};
            op_b = {{(MUL_W-PP_W){1'b0}}, poles_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   // filter accumulate; the bit-select is a floor shift by 16
   assign acc_sum = {acc_ff[ACC_W-1], acc_ff} + {prod_ff[ACC_W-1], prod_ff[ACC_W-1:0]};
   assign acc_shr = acc_sum[ACC_W:16];

   always_ff @(posedge clock) begin
      if (state_ff == SEQ_RUN) begin
         unique case (uc.wb)
            WB_FRAC:  frac_ff  <= prod_ff[WORD_W-1:0];
            WB_RAW:   raw_ff   <= sat32(prod_ff);
            WB_EFRAC: efrac_ff <= prod_ff[WORD_W-1:0];
            WB_MANG:  mang_ff  <= prod_ff[63:45];
            WB_EANG:  eang_ff  <= prod_ff[63:45];
            WB_ACC:   acc_ff   <= prod_ff[ACC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sampled_ff <= '0;
         low_ff     <= '0;
         prev_ff    <= '0;
         mech_ff    <= '0;
         elec_ff    <= '0;
      end else if (state_ff == SEQ_RUN) begin
         unique case (uc.wb)
            WB_LOW: begin
               low_ff     <= sat32({{(PROD_W-ACC_W+15){acc_shr[ACC_W-16]}}, acc_shr});
               prev_ff    <= raw_ff;
               sampled_ff <= pos_ff;
            end
            WB_MECH: mech_ff <= prod_ff[63:32];
            WB_ELEC: elec_ff <= sat32(prod_ff);
            default: ;
         endcase
      end
   end

   // ---------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (emit) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_tdata_ff <= {2'b00, elec_ff, mech_ff, low_ff, eang_ff, mang_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

@@ sv/qenc_chk.sv @@
// qenc_chk: port-level checks on encoder_angle_speed_estimator, bound to it below.
// Depends on qenc_pkg for widths.
module qenc_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [qenc_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import qenc_pkg::*;

   // out of reset the block is empty and ready
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("not idle after reset");

   // one item at a time: the sequencer is busy right after a transfer
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while sequencer busy");

   // a new result appears only as the sequencer goes back to idle
   a_result_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result raised while sequencer still running");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

endmodule

bind encoder_angle_speed_estimator qenc_chk u_qenc_chk (.*);
